[rtl/wbps_pkg.sv]
// Shared constants, register indexes and types of the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int unsigned PATTERN_BYTES_DEF = 16;
   localparam int unsigned CSR_INDEX_W       = 3;
   localparam int unsigned CSR_DATA_W        = 64;
   localparam int unsigned ADDR_W            = 32;
   localparam int unsigned PLEN_W            = 5;

   localparam logic [ADDR_W-1:0] START_ADDRESS_RESET = 32'd4096;
   localparam logic [ADDR_W-1:0] POSITION_LIMIT      = 32'hFFFF_FFFF;
   localparam logic [PLEN_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_RESULT_OFFSET  = 3'd3,
      CSR_START_ADDRESS  = 3'd4,
      CSR_END_ADDRESS    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_item_type;

endpackage

[rtl/wildcard_byte_pattern_scanner.sv]
// Top level of the wildcard byte pattern scanner: config, window cell chain, result logic.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid/req_ready, data_byte, last_byte | in
//   rsp     | rsp_valid/rsp_ready, found, match_address | out
//   csr     | csr_write, csr_index, csr_wdata           | in
//
// One item per cycle while req_ready is high; an item's result (if any) is in the queue the next cycle.
// The window is a chain of PATTERN_BYTES cells, each comparing the byte it takes in
// against its pattern byte, so the match test finishes in the cycle of acceptance.
// req_ready drops only while both result slots hold items nobody has taken.
// Reset is synchronous; it clears the scan state and the result queue and returns the registers to reset values.
// The last byte of a buffer returns the scan state to reset; registers are kept.
module wildcard_byte_pattern_scanner #(
   parameter int unsigned PATTERN_BYTES = wbps_pkg::PATTERN_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [wbps_pkg::ADDR_W-1:0]        rsp_match_address,
   input  logic                               csr_write,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int unsigned LW = $clog2(PATTERN_BYTES + 1);
   localparam int unsigned AW = wbps_pkg::ADDR_W;

   // configuration registers
   logic [63:0]                  pat_low_ff;
   logic [63:0]                  pat_high_ff;
   logic [wbps_pkg::PLEN_W-1:0]  plen_ff;
   logic [AW-1:0]                offset_ff;
   logic [AW-1:0]                start_ff;
   logic [AW-1:0]                end_ff;

   // scan state
   logic [AW-1:0] pos_ff, pos_in;
   logic [LW-1:0] seen_ff, seen_in;
   logic          reported_ff, reported_in;

   logic                         accept;
   logic                         scan;
   logic [LW-1:0]                seen_next;
   logic [LW-1:0]                len_eff;
   logic [AW-1:0]                match_start;
   logic                         in_range;
   logic                         window_hit;
   logic                         hit;
   logic                         push;
   wbps_pkg::rsp_item_type       push_item;
   wbps_pkg::rsp_item_type       head_item;
   logic                         queue_full;
   logic [127:0]                 pat_all;
   logic [PATTERN_BYTES*8-1:0]   pattern;
   logic [7:0]                   cell_byte [PATTERN_BYTES];
   logic [PATTERN_BYTES-1:0]     cell_hit;

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         plen_ff     <= wbps_pkg::PATTERN_LENGTH_RESET;
         offset_ff   <= '0;
         start_ff    <= wbps_pkg::START_ADDRESS_RESET;
         end_ff      <= '0;
      end else if (csr_write) begin
         unique case (wbps_pkg::csr_index_type'(csr_index))
            wbps_pkg::CSR_PATTERN_LOW:    pat_low_ff  <= csr_wdata;
            wbps_pkg::CSR_PATTERN_HIGH:   pat_high_ff <= csr_wdata;
            wbps_pkg::CSR_PATTERN_LENGTH: plen_ff     <= csr_wdata[wbps_pkg::PLEN_W-1:0];
            wbps_pkg::CSR_RESULT_OFFSET:  offset_ff   <= csr_wdata[AW-1:0];
            wbps_pkg::CSR_START_ADDRESS:  start_ff    <= csr_wdata[AW-1:0];
            wbps_pkg::CSR_END_ADDRESS:    end_ff      <= csr_wdata[AW-1:0];
            default: ;
         endcase
      end
   end

   // Length clamped to 1..PATTERN_BYTES.
   always_comb begin
      if (plen_ff == '0)
         len_eff = LW'(1);
      else if (32'(plen_ff) > 32'(PATTERN_BYTES))
         len_eff = LW'(PATTERN_BYTES);
      else
         len_eff = LW'(plen_ff);
   end

   assign pat_all = {pat_high_ff, pat_low_ff};
   assign pattern = pat_all[PATTERN_BYTES*8-1:0];

   // ---- handshake ----
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   // The top position is never scanned; the stream parks there.
   assign scan      = pos_ff != wbps_pkg::POSITION_LIMIT;

   // ---- window cell chain: cell 0 takes the newest byte ----
   for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
      logic [7:0] shift_data;
      if (k == 0) begin : g_head
         assign shift_data = req_data_byte;
      end else begin : g_link
         assign shift_data = cell_byte[k-1];
      end
      wbps_cell #(
         .PATTERN_BYTES (PATTERN_BYTES),
         .INDEX         (k)
      ) u_cell (
         .clock      (clock),
         .shift_en   (accept && scan),
         .shift_data (shift_data),
         .pattern    (pattern),
         .len_eff    (len_eff),
         .byte_out   (cell_byte[k]),
         .hit        (cell_hit[k])
      );
   end

   assign window_hit = &cell_hit;

   // ---- match decision ----
   assign seen_next   = (seen_ff < LW'(PATTERN_BYTES)) ? seen_ff + LW'(1) : seen_ff;
   assign match_start = pos_ff - AW'(len_eff - LW'(1));
   assign in_range    = (match_start >= start_ff) && (match_start < end_ff);
   assign hit         = scan && !reported_ff && (seen_next >= len_eff) && in_range
                        && window_hit;

   always_comb begin
      push_item.found         = hit;
      push_item.match_address = hit ? match_start + offset_ff : '0;
      // a miss result goes out only at the end of a buffer with nothing reported
      push = accept && (hit || (req_last_byte && !reported_ff));
   end

   // ---- scan state update ----
   always_comb begin
      pos_in      = pos_ff;
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_last_byte) begin
            pos_in      = '0;
            seen_in     = '0;
            reported_in = 1'b0;
         end else if (scan) begin
            pos_in      = pos_ff + AW'(1);
            seen_in     = seen_next;
            reported_in = reported_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   // ---- result queue ----
   wbps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head_item (head_item)
   );

   assign rsp_found         = head_item.found;
   assign rsp_match_address = head_item.match_address;

endmodule

[rtl/wbps_cell.sv]
// One window cell: holds a stream byte, passes it on, and checks it against its pattern byte.
module wbps_cell #(
   parameter int unsigned PATTERN_BYTES = wbps_pkg::PATTERN_BYTES_DEF,
   parameter int unsigned INDEX         = 0
) (
   input  logic                                      clock,
   input  logic                                      shift_en,
   input  logic [7:0]                                shift_data,
   input  logic [PATTERN_BYTES*8-1:0]                pattern,
   input  logic [$clog2(PATTERN_BYTES+1)-1:0]        len_eff,
   output logic [7:0]                                byte_out,
   output logic                                      hit
);
   localparam int unsigned LW = $clog2(PATTERN_BYTES + 1);
   localparam int unsigned NW = $clog2(PATTERN_BYTES);

   logic [7:0]    win_ff;
   logic [7:0]    win_in;
   logic          used;
   logic [LW-1:0] pidx_full;
   logic [NW-1:0] pidx;
   logic [7:0]    pbyte;
   logic          wild;

   assign win_in = shift_en ? shift_data : win_ff;

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign byte_out = win_ff;

   // This cell carries pattern byte len-1-INDEX after the shift.
   assign used      = len_eff > LW'(INDEX);
   assign pidx_full = len_eff - LW'(1) - LW'(INDEX);
   assign pidx      = pidx_full[NW-1:0];
   assign pbyte     = pattern[pidx*8 +: 8];
   // Zero is a wildcard everywhere except the first pattern byte.
   assign wild      = (pidx != '0) && (pbyte == 8'h00);
   assign hit       = !used || wild || (shift_data == pbyte);

endmodule

[rtl/wbps_rsp_queue.sv]
// Two-slot result queue: output register plus skid slot.
module wbps_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  wbps_pkg::rsp_item_type   push_item,
   output logic                     full,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output wbps_pkg::rsp_item_type   head_item
);
   wbps_pkg::rsp_item_type slot0_ff, slot0_in;
   wbps_pkg::rsp_item_type slot1_ff, slot1_in;
   logic [1:0]             count_ff, count_in;
   logic                   pop;

   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign rsp_valid = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign head_item = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) slot0_in = push_item;
            else                  slot1_in = push_item;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_item;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_item;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) count_ff <= 2'd0;
      else       count_ff <= count_in;
   end

endmodule

[tb/sv/wildcard_byte_pattern_scanner_checker.sv]
// Checker for the wildcard byte pattern scanner: tracks registers, predicts reports, compares.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_checker #(
   parameter int unsigned PATTERN_BYTES = wbps_pkg::PATTERN_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last_byte,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_found,
   input  logic [wbps_pkg::ADDR_W-1:0]        rsp_match_address,
   input  logic                               csr_write,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int unsigned                        pending_count,
   output int unsigned                        error_count
);

   wbps_pkg::rsp_item_type pending_reports [$];

   // register copy
   logic [127:0] pattern;
   logic [4:0]   pattern_length;
   logic [31:0]  result_offset;
   logic [31:0]  start_address;
   logic [31:0]  end_address;

   // scan state, window[0] is the newest byte
   logic [7:0]   window [PATTERN_BYTES];
   logic [31:0]  position;
   logic         reported;
   int unsigned  filled;

   int unsigned  mismatches = 0;

   function automatic int unsigned active_length();
      if (pattern_length == 5'd0) return 1;
      if (pattern_length > PATTERN_BYTES) return PATTERN_BYTES;
      return pattern_length;
   endfunction

   task automatic clear_scan();
      for (int k = 0; k < PATTERN_BYTES; k++) window[k] = 8'h00;
      position = '0;
      reported = 1'b0;
      filled   = 0;
   endtask

   task automatic scan_byte(input logic [7:0] data, input logic last);
      int unsigned            len;
      logic [31:0]            pos;
      logic [31:0]            s;
      logic                   hit;
      logic [7:0]             pb;
      wbps_pkg::rsp_item_type rep;
      // position pinned at the top: byte is not scanned
      if (position != wbps_pkg::POSITION_LIMIT) begin
         for (int k = PATTERN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = data;
         if (filled < PATTERN_BYTES) filled++;
         pos      = position;
         position = pos + 32'd1;
         len      = active_length();
         if (!reported && filled >= len) begin
            s = pos - (len - 1);
            if (s >= start_address && s < end_address) begin
               // first pattern byte always compares exactly, zero or not
               hit = (window[len-1] == pattern[7:0]);
               for (int unsigned n = 1; n < len; n++) begin
                  pb = pattern[8*n +: 8];
                  if (pb != 8'h00 && window[len-1-n] != pb) hit = 1'b0;
               end
               if (hit) begin
                  reported          = 1'b1;
                  rep.found         = 1'b1;
                  rep.match_address = s + result_offset;
                  pending_reports   = {pending_reports, rep};
               end
            end
         end
      end
      if (last) begin
         if (!reported) begin
            rep.found         = 1'b0;
            rep.match_address = '0;
            pending_reports   = {pending_reports, rep};
         end
         clear_scan();
      end
   endtask

   task automatic check_report(input logic found, input logic [31:0] address);
      wbps_pkg::rsp_item_type want;
      if (pending_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result found=%0b address=%h", $time, found, address);
      end else begin
         want = pending_reports.pop_front();
         if (want.found !== found || want.match_address !== address) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: result mismatch: expected found=%0b address=%h,",
                         " got found=%0b address=%h"},
                        $time, want.found, want.match_address, found, address);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_reports.delete();
         pattern        = '0;
         pattern_length = wbps_pkg::PATTERN_LENGTH_RESET;
         result_offset  = '0;
         start_address  = wbps_pkg::START_ADDRESS_RESET;
         end_address    = '0;
         clear_scan();
      end else begin
         // a result leaves in the cycle after its item at the earliest, so drain first
         if (rsp_valid && rsp_ready) check_report(rsp_found, rsp_match_address);
         if (req_valid && req_ready) scan_byte(req_data_byte, req_last_byte);
         if (csr_write) begin
            case (csr_index)
               wbps_pkg::CSR_PATTERN_LOW:    pattern[63:0]   = csr_wdata;
               wbps_pkg::CSR_PATTERN_HIGH:   pattern[127:64] = csr_wdata;
               wbps_pkg::CSR_PATTERN_LENGTH: pattern_length  = csr_wdata[4:0];
               wbps_pkg::CSR_RESULT_OFFSET:  result_offset   = csr_wdata[31:0];
               wbps_pkg::CSR_START_ADDRESS:  start_address   = csr_wdata[31:0];
               wbps_pkg::CSR_END_ADDRESS:    end_address     = csr_wdata[31:0];
               default: ;
            endcase
         end
      end
      pending_count <= pending_reports.size();
      error_count   <= mismatches;
   end

endmodule

[tb/sv/wildcard_byte_pattern_scanner_tb.sv]
// Top of the wildcard byte pattern scanner testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_tb;

   localparam int unsigned ITEM_TARGET    = 1550;
   localparam int unsigned PHASE_ITEMS    = 120;
   localparam int unsigned DRAIN_CYCLES   = 4;    // result shows up the cycle after its item
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [7:0]                         req_data_byte;
   logic                               req_last_byte;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_found;
   logic [wbps_pkg::ADDR_W-1:0]        rsp_match_address;
   logic                               csr_write;
   wbps_pkg::csr_index_type            csr_index;
   logic [wbps_pkg::CSR_DATA_W-1:0]    csr_wdata;

   int unsigned pending_count;
   int unsigned error_count;

   // stimulus-side copy of the pattern, used to build buffers that hit
   logic [7:0]  pat [16];
   int unsigned eff_len;

   int unsigned burst_left  = 0;
   int unsigned sent_items  = 0;
   int unsigned idle_cycles = 0;

   rx_mode_type rx_mode = RX_OPEN;
   int unsigned rx_run  = 0;

   wildcard_byte_pattern_scanner dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   wildcard_byte_pattern_scanner_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .pending_count     (pending_count),
      .error_count       (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: runs of always-ready, coin-flip, mostly-stalled and fully-held cycles.
   // A held run is kept short so the watchdog never mistakes it for a hang.
   always @(posedge clock) begin
      if (rx_run == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_run  = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
      end
      rx_run--;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
         default:   rsp_ready <= 1'b0;
      endcase
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("wildcard_byte_pattern_scanner_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put_reg(input wbps_pkg::csr_index_type idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all six registers back to back. The narrow ones get junk in the unused
   // upper bits, which the block has to drop.
   task automatic program_scan(input logic [127:0] pattern, input logic [4:0] plen,
                               input logic [31:0] offs, input logic [31:0] sa,
                               input logic [31:0] ea);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      for (int n = 0; n < 16; n++) pat[n] = pattern[8*n +: 8];
      eff_len = (plen == 5'd0) ? 1 : (plen > 16) ? 16 : plen;
      put_reg(wbps_pkg::CSR_PATTERN_LOW,    pattern[63:0]);
      put_reg(wbps_pkg::CSR_PATTERN_HIGH,   pattern[127:64]);
      put_reg(wbps_pkg::CSR_PATTERN_LENGTH, {junk[63:5], plen});
      put_reg(wbps_pkg::CSR_RESULT_OFFSET,  {junk[63:32], offs});
      put_reg(wbps_pkg::CSR_START_ADDRESS,  {junk[31:0], sa});
      put_reg(wbps_pkg::CSR_END_ADDRESS,    {junk[47:16], ea});
      csr_write <= 1'b0;
   endtask

   // One item. Bursts of random length, with a random gap before each new burst;
   // long bursts with no gap give back-to-back stretches.
   task automatic offer_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      sent_items++;
   endtask

   // Drop valid, let every expected result drain, then allow for an item still
   // in flight that produces nothing. Registers may be written after this.
   task automatic quiesce();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Data byte that satisfies pattern byte n; wildcards get anything.
   function automatic logic [7:0] pattern_fill(input int unsigned n);
      if (n != 0 && pat[n] == 8'h00) return 8'($urandom_range(0, 255));
      return pat[n];
   endfunction

   // Most buffers carry the pattern (sometimes broken, sometimes twice) between
   // random bytes; the rest are plain noise.
   task automatic send_buffer();
      logic [7:0]  frame [64];
      int unsigned count;
      int unsigned bad;
      logic [7:0]  b;
      count = 0;
      if ($urandom_range(0, 3) != 0) begin
         repeat ($urandom_range(0, 10)) begin
            // stray copies of the lead byte make false starts
            frame[count] = ($urandom_range(0, 3) == 0) ? pat[0] : 8'($urandom_range(0, 255));
            count++;
         end
         bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff_len - 1) : 99;
         for (int unsigned n = 0; n < eff_len; n++) begin
            b = pattern_fill(n);
            if (n == bad) b = b ^ 8'($urandom_range(1, 255));
            frame[count] = b;
            count++;
         end
         // a second hit in the same buffer must be ignored
         if ($urandom_range(0, 5) == 0) begin
            for (int unsigned n = 0; n < eff_len; n++) begin
               frame[count] = pattern_fill(n);
               count++;
            end
         end
         repeat ($urandom_range(0, 6)) begin
            frame[count] = 8'($urandom_range(0, 255));
            count++;
         end
      end else begin
         count = $urandom_range(1, 20);
         for (int unsigned n = 0; n < count; n++) frame[n] = 8'($urandom_range(0, 255));
      end
      for (int unsigned n = 0; n < count; n++) offer_byte(frame[n], n == count - 1);
   endtask

   // Register set for one phase: the first few pin the extremes, the rest are random
   // with a narrow start/end range so that hits land both inside and outside it.
   task automatic choose_settings(input int unsigned phase);
      logic [127:0] pattern;
      logic [4:0]   plen;
      logic [31:0]  offs;
      logic [31:0]  sa;
      logic [31:0]  ea;
      pattern = {$urandom(), $urandom(), $urandom(), $urandom()};
      for (int n = 1; n < 16; n++)
         if ($urandom_range(0, 2) == 0) pattern[8*n +: 8] = 8'h00;
      if ($urandom_range(0, 7) == 0) pattern[7:0] = 8'h00;
      plen = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(1, 8));
      case ($urandom_range(0, 4))
         0:       offs = 32'h7FFF_FFFF;
         1:       offs = 32'h8000_0000;
         2:       offs = 32'hFFFF_FFFF;
         default: offs = $urandom();
      endcase
      sa = $urandom_range(0, 6);
      ea = sa + $urandom_range(1, 40);
      case (phase)
         0: begin
            plen = 5'd1;
            offs = '0;
            sa   = '0;
            ea   = '1;
         end
         1: begin
            pattern = '1;
            plen    = 5'd16;
            offs    = 32'h7FFF_FFFF;
            sa      = 32'd3;
            ea      = 32'd24;
         end
         2: begin
            // lead byte zero, everything after it a wildcard, length above the maximum
            pattern = '0;
            plen    = 5'd31;
            offs    = 32'h8000_0000;
            sa      = '0;
            ea      = 32'd12;
         end
         3: begin
            plen = 5'd17;
            sa   = 32'd5;
            ea   = 32'd5;
         end
         4: begin
            plen = 5'd0;
            sa   = '1;
            ea   = '1;
         end
         5: begin
            sa   = 32'd20;
            ea   = 32'd3;
            offs = 32'hFFFF_FFFF;
         end
         default: ;
      endcase
      program_scan(pattern, plen, offs, sa, ea);
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_end;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      csr_write     = 1'b0;
      csr_index     = wbps_pkg::CSR_PATTERN_LOW;
      csr_wdata     = '0;
      for (int n = 0; n < 16; n++) pat[n] = 8'h00;
      eff_len = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset values: start above end, so a buffer can only end without a hit.
      offer_byte(8'h00, 1'b0);
      offer_byte(8'h00, 1'b1);
      quiesce();

      // Zero lead byte must match exactly, length zero acts as one, offset sets the top address bit.
      program_scan({64'($urandom()), 64'h0}, 5'd0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h00, 1'b0);
      offer_byte(8'hFF, 1'b1);
      // hit on the final byte: only the hit is reported
      offer_byte(8'h00, 1'b1);
      offer_byte(8'hFF, 1'b1);
      quiesce();

      // Full-width pattern with wildcards, hit at position 0 with offset -1,
      // completing on the final byte.
      program_scan({64'h8000_0000_0000_0001, 64'h00A5_0000_3C00_00FF}, 5'd16,
                   32'hFFFF_FFFF, 32'h0, 32'h1);
      for (int unsigned n = 0; n < 16; n++) offer_byte(pattern_fill(n), n == 15);

      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         quiesce();
         choose_settings(phase);
         phase_end = sent_items + PHASE_ITEMS;
         while (sent_items < phase_end && sent_items < ITEM_TARGET) send_buffer();
         phase++;
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("wildcard_byte_pattern_scanner_tb: done, clean");
      end else begin
         $display("wildcard_byte_pattern_scanner_tb: done, errors");
      end
      $finish;
   end

endmodule
